/* rtl/core/pdrc_pkg.sv */
package pdrc_pkg;

	localparam int WORD_W  = 64;
	localparam int NIBBLE_W = 4;
	localparam int BASE_W  = 5;
	localparam int CFG_IDX_W = 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_BASE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_BASE = 1'd1;

	localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
	localparam logic [BASE_W-1:0] BASE_HEX   = 5'd16;
	localparam logic [BASE_W-1:0] IN_BASE_RESET  = 5'd10;
	localparam logic [BASE_W-1:0] OUT_BASE_RESET = 5'd16;

	// Clamp a base register value to the range 2..16.
	function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
		logic [BASE_W-1:0] r;
		r = b;
		if (b < BASE_MIN) r = BASE_MIN;
		if (b > BASE_HEX) r = BASE_HEX;
		return r;
	endfunction

endpackage

/* rtl/core/packed_digit_radix_converter.sv */
// Packed-digit radix converter.
// Configuration: write cfg_index/cfg_data with cfg_valid; cfg_ready is always
// high. Index 0 is the input base, index 1 the output base (2..16, clamped;
// 16 means the word is taken or given as plain hex). Write only while idle.
// An item is accepted when start is high and busy is low; busy is never set,
// so an item may enter every cycle. The item flows through a chain of
// DIGIT_COUNT Horner cells (one input digit each, top digit first) followed
// by 64 doubling cells (one bit of the value each, top bit first) that build
// the output digits, and one output register.
// done follows the item through the read cells, the doubling cells and the
// output register; throughput is one item per cycle, since every cell
// hands its item on in each cycle.
// The result appears on packed_digits_out for exactly one cycle with done
// high; the receiver cannot stall it.
// Reset clears all valid flags in the chain and loads the bases with 10
// (input) and 16 (output); items in flight at reset are dropped.
module packed_digit_radix_converter #(
	parameter int DIGIT_COUNT = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [pdrc_pkg::WORD_W-1:0]          packed_digits_in,
	output logic                                 done,
	output logic [pdrc_pkg::WORD_W-1:0]          packed_digits_out,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pdrc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pdrc_pkg::BASE_W-1:0]          cfg_data
);

	localparam int N = DIGIT_COUNT;
	localparam int B = pdrc_pkg::WORD_W;

	logic [pdrc_pkg::BASE_W-1:0] in_base_q;
	logic [pdrc_pkg::BASE_W-1:0] out_base_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_base_q  <= pdrc_pkg::IN_BASE_RESET;
			out_base_q <= pdrc_pkg::OUT_BASE_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == pdrc_pkg::REG_INPUT_BASE) in_base_q <= cfg_data;
			if (cfg_index == pdrc_pkg::REG_OUTPUT_BASE) out_base_q <= cfg_data;
		end
	end

	// Read chain.
	logic                          rv   [0:N];
	logic [pdrc_pkg::WORD_W-1:0]   racc [0:N];
	logic [pdrc_pkg::WORD_W-1:0]   rwrd [0:N];
	logic [pdrc_pkg::BASE_W-1:0]   rib  [0:N];
	logic [pdrc_pkg::BASE_W-1:0]   rob  [0:N];

	assign rv[0]   = start;
	assign racc[0] = '0;
	assign rwrd[0] = packed_digits_in;
	assign rib[0]  = pdrc_pkg::clamp_base(in_base_q);
	assign rob[0]  = pdrc_pkg::clamp_base(out_base_q);

	for (genvar g = 0; g < N; g++) begin : g_read
		pdrc_read_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.valid_in(rv[g]), .acc_in(racc[g]), .word_in(rwrd[g]),
			.ibase_in(rib[g]), .obase_in(rob[g]),
			.digit(rwrd[g][(N-1-g)*pdrc_pkg::NIBBLE_W +: pdrc_pkg::NIBBLE_W]),
			.valid_out(rv[g+1]), .acc_out(racc[g+1]), .word_out(rwrd[g+1]),
			.ibase_out(rib[g+1]), .obase_out(rob[g+1])
		);
	end

	// Value after reading: hex base takes the whole word.
	logic                        wv   [0:B];
	logic [pdrc_pkg::WORD_W-1:0] wval [0:B];
	logic [pdrc_pkg::WORD_W-1:0] wres [0:B];
	logic [pdrc_pkg::BASE_W-1:0] wob  [0:B];

	assign wv[0]   = rv[N];
	assign wval[0] = (rib[N] == pdrc_pkg::BASE_HEX) ? rwrd[N] : racc[N];
	assign wres[0] = '0;
	assign wob[0]  = rob[N];

	// Write chain: one cell per bit of the value, top bit first.
	for (genvar g = 0; g < B; g++) begin : g_write
		pdrc_write_cell #(.DIGIT_COUNT(N), .BIT_IDX(B - 1 - g)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.valid_in(wv[g]), .val_in(wval[g]), .res_in(wres[g]),
			.obase_in(wob[g]),
			.valid_out(wv[g+1]), .val_out(wval[g+1]), .res_out(wres[g+1]),
			.obase_out(wob[g+1])
		);
	end

	// Output register; a hex output base passes the value carried along.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= wv[B];
		end
	end

	always_ff @(posedge clk) begin
		packed_digits_out <= (wob[B] == pdrc_pkg::BASE_HEX) ? wval[B] : wres[B];
	end

endmodule

/* rtl/core/pdrc_read_cell.sv */
// One Horner step: acc * base + digit, modulo 2^64, with the word and bases
// handed on to the next cell.
module pdrc_read_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid_in,
	input  logic [pdrc_pkg::WORD_W-1:0]      acc_in,
	input  logic [pdrc_pkg::WORD_W-1:0]      word_in,
	input  logic [pdrc_pkg::BASE_W-1:0]      ibase_in,
	input  logic [pdrc_pkg::BASE_W-1:0]      obase_in,
	input  logic [pdrc_pkg::NIBBLE_W-1:0]    digit,
	output logic                             valid_out,
	output logic [pdrc_pkg::WORD_W-1:0]      acc_out,
	output logic [pdrc_pkg::WORD_W-1:0]      word_out,
	output logic [pdrc_pkg::BASE_W-1:0]      ibase_out,
	output logic [pdrc_pkg::BASE_W-1:0]      obase_out
);

	logic [pdrc_pkg::WORD_W-1:0] next_acc;

	// Narrow multiplier: 64 bits by a 5-bit base.
	assign next_acc = acc_in * {59'd0, ibase_in} + {60'd0, digit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		acc_out   <= next_acc;
		word_out  <= word_in;
		ibase_out <= ibase_in;
		obase_out <= obase_in;
	end

endmodule

/* rtl/core/pdrc_write_cell.sv */
// One doubling step of the binary to output base conversion. The running
// digits in the output base are doubled and one bit of the value, top bit
// first, is added in; the value and the base are handed on to the next cell.
module pdrc_write_cell #(
	parameter int DIGIT_COUNT = 16,
	parameter int BIT_IDX = 63
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid_in,
	input  logic [pdrc_pkg::WORD_W-1:0]      val_in,
	input  logic [pdrc_pkg::WORD_W-1:0]      res_in,
	input  logic [pdrc_pkg::BASE_W-1:0]      obase_in,
	output logic                             valid_out,
	output logic [pdrc_pkg::WORD_W-1:0]      val_out,
	output logic [pdrc_pkg::WORD_W-1:0]      res_out,
	output logic [pdrc_pkg::BASE_W-1:0]      obase_out
);

	logic [DIGIT_COUNT-1:0]      carry;
	logic [pdrc_pkg::WORD_W-1:0] res_next;

	assign carry[0] = val_in[BIT_IDX];

	// Each digit becomes 2*d + carry; at or above the base it wraps and
	// carries one into the next digit. The carry out of the top digit is
	// dropped, which keeps the digits modulo base^DIGIT_COUNT.
	for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_digit
		logic [pdrc_pkg::NIBBLE_W-1:0] d;
		logic [pdrc_pkg::BASE_W-1:0]   dbl;
		logic [pdrc_pkg::BASE_W-1:0]   dsub;
		logic                          ge0;
		logic                          ge1;
		logic                          cout;

		assign d    = res_in[i*pdrc_pkg::NIBBLE_W +: pdrc_pkg::NIBBLE_W];
		assign ge0  = ({d, 1'b0} >= obase_in);
		assign ge1  = ({d, 1'b1} >= obase_in);
		assign cout = carry[i] ? ge1 : ge0;
		assign dbl  = {d, carry[i]};
		assign dsub = dbl - obase_in;
		assign res_next[i*pdrc_pkg::NIBBLE_W +: pdrc_pkg::NIBBLE_W] =
			cout ? dsub[pdrc_pkg::NIBBLE_W-1:0] : dbl[pdrc_pkg::NIBBLE_W-1:0];
		if (i < DIGIT_COUNT - 1) begin : g_link
			assign carry[i+1] = cout;
		end
	end

	// Nibbles above the digit count stay zero.
	if (DIGIT_COUNT < 16) begin : g_upper
		assign res_next[pdrc_pkg::WORD_W-1:DIGIT_COUNT*pdrc_pkg::NIBBLE_W] = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		val_out   <= val_in;
		res_out   <= res_next;
		obase_out <= obase_in;
	end

endmodule
